// ===== sv/hfp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hex frame parser package
// Shared types, codes and helper functions for the hex frame parser.
// ----------------------------------------------------------------------------
package hfp_pkg;

   localparam int MAX_FRAME_BYTES_DEF = 127;

   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   localparam logic [7:0]  CHAR_SPACE = 8'h20;
   localparam logic [7:0]  CHAR_CLOSE = 8'h5D;
   localparam logic [15:0] CRC_POLY   = 16'h8408;
   localparam logic [7:0]  LINK_DEF   = 8'hFF;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_LEN,
      PH_SEP,
      PH_BYTE,
      PH_GAP,
      PH_T1,
      PH_T1END,
      PH_RSSI,
      PH_GAP2,
      PH_STATUS,
      PH_CLOSE
   } phase_type;

   typedef enum logic [1:0] {
      ERR_OK     = 2'd0,
      ERR_LENGTH = 2'd1,
      ERR_SYNTAX = 2'd2,
      ERR_STATUS = 2'd3
   } err_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       last;
      err_type    error_code;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] nibble;
   } hex_type;

   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type h;
      h.ok     = 1'b1;
      h.nibble = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.nibble = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         h.nibble = 4'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         h.nibble = 4'(c - 8'h37);
      end else begin
         h.ok = 1'b0;
      end
      return h;
   endfunction

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic rsp_type end_word(input err_type err);
      rsp_type r;
      r.data_byte  = 8'h00;
      r.byte_valid = 1'b0;
      r.last       = 1'b1;
      r.error_code = err;
      return r;
   endfunction

endpackage

// ===== sv/hex_frame_parser_crc_lqi_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hex frame parser with CRC check and LQI/RSSI packing
// Parses the ASCII hex text of a captured radio frame and emits its bytes.
// ----------------------------------------------------------------------------
// The request channel carries one text character per word, with line_start
// marking the first character of a frame. The response channel carries one
// result word per handshake: a frame byte, the substituted RSSI and LQI bytes,
// or a closing word with an error code.
// A character is parsed in the cycle it is accepted; its results enter the
// result queue in the next cycle and reach the response channel behind older words.
// While req_stall is low the block takes one character per cycle. A character
// that closes a frame of length two or more yields two result words, and the
// four-entry result queue drains one word per cycle while rsp_stall is low.
// req_stall rises when fewer than two queue entries are free, which happens
// only while the receiver holds rsp_stall or after a burst of closing words.
// While stalled, the head word holds steady on the response ports.
// Reset empties the queue and returns the parser to idle, where characters
// are ignored until line_start is seen.
// ----------------------------------------------------------------------------
module hex_frame_parser_crc_lqi_top #(
   parameter int MAX_FRAME_BYTES = hfp_pkg::MAX_FRAME_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_char,
   input  logic       req_line_start,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_last,
   output logic [1:0] rsp_error_code
);
   import hfp_pkg::*;

   logic     take;
   logic     room;
   logic     not_empty;
   push_type push;
   rsp_type  head;

   assign req_stall = !room;
   assign take      = req_valid && room;

   hfp_parse #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) u_parse (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .in_char    (req_in_char),
      .line_start (req_line_start),
      .push       (push)
   );

   hfp_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (take ? push : push_type'('0)),
      .pop       (not_empty && !rsp_stall),
      .room      (room),
      .not_empty (not_empty),
      .head      (head)
   );

   assign rsp_valid      = not_empty;
   assign rsp_data_byte  = head.data_byte;
   assign rsp_byte_valid = head.byte_valid;
   assign rsp_last       = head.last;
   assign rsp_error_code = head.error_code;

endmodule

// ===== sv/hfp_parse.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hex frame parser core
// Decodes one character per accepted word, keeps the frame state and the
// running CRC, and produces zero, one or two result words.
// ----------------------------------------------------------------------------
module hfp_parse #(
   parameter int MAX_FRAME_BYTES = hfp_pkg::MAX_FRAME_BYTES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             take,
   input  logic [7:0]       in_char,
   input  logic             line_start,
   output hfp_pkg::push_type push
);
   import hfp_pkg::*;

   localparam int         LW    = $clog2(MAX_FRAME_BYTES + 1);
   localparam logic [7:0] MAX_V = 8'(MAX_FRAME_BYTES);

   phase_type   phase_ff, phase_in, cur_phase;
   logic [LW-1:0] fl_ff, fl_in, cur_fl;
   logic [LW-1:0] bc_ff, bc_in, cur_bc;
   logic [LW:0]   bc_next;
   logic [15:0] crc_ff, crc_in, cur_crc;
   logic [3:0]  hn_ff, hn_in, cur_hn;
   logic        dp_ff, dp_in, cur_dp;
   logic [7:0]  lqi_ff, lqi_in, cur_lqi;
   logic [7:0]  rssi_ff, rssi_in, cur_rssi;
   logic        st_ff, st_in, cur_st;
   hex_type     hx;
   logic [7:0]  v;
   logic [7:0]  fin_lqi;
   logic        held;
   push_type    fin;

   always_comb begin
      if (line_start) begin
         cur_phase = PH_LEN;
         cur_fl    = '0;
         cur_bc    = '0;
         cur_crc   = '0;
         cur_hn    = '0;
         cur_dp    = 1'b0;
         cur_lqi   = LINK_DEF;
         cur_rssi  = LINK_DEF;
         cur_st    = 1'b0;
      end else begin
         cur_phase = phase_ff;
         cur_fl    = fl_ff;
         cur_bc    = bc_ff;
         cur_crc   = crc_ff;
         cur_hn    = hn_ff;
         cur_dp    = dp_ff;
         cur_lqi   = lqi_ff;
         cur_rssi  = rssi_ff;
         cur_st    = st_ff;
      end
   end

   assign hx      = hex_decode(in_char);
   assign v       = {cur_hn, hx.nibble};
   assign bc_next = {1'b0, cur_bc} + (LW + 1)'(1);
   assign held    = (cur_fl >= LW'(2)) && (cur_bc >= cur_fl - LW'(2));
   assign fin_lqi = (cur_phase == PH_T1END) ? LINK_DEF : cur_lqi;

   always_comb begin
      fin = '0;
      if (cur_fl >= LW'(2)) begin
         fin.count             = 2'd2;
         fin.first.data_byte   = cur_rssi;
         fin.first.byte_valid  = 1'b1;
         fin.first.error_code  = ERR_OK;
         fin.second.data_byte  = {(cur_crc == 16'h0000), fin_lqi[6:0]};
         fin.second.byte_valid = 1'b1;
         fin.second.last       = 1'b1;
         fin.second.error_code = ERR_OK;
      end else begin
         fin.count = 2'd1;
         fin.first = end_word(ERR_OK);
      end
   end

   always_comb begin
      phase_in = cur_phase;
      fl_in    = cur_fl;
      bc_in    = cur_bc;
      crc_in   = cur_crc;
      hn_in    = cur_hn;
      dp_in    = cur_dp;
      lqi_in   = cur_lqi;
      rssi_in  = cur_rssi;
      st_in    = cur_st;
      push     = '0;
      unique case (cur_phase)
         PH_SEP: begin
            if (in_char != CHAR_SPACE) begin
               phase_in   = PH_IDLE;
               push.count = 2'd1;
               push.first = end_word(ERR_SYNTAX);
            end else begin
               phase_in = PH_BYTE;
            end
         end
         PH_GAP: begin
            phase_in = PH_T1;
         end
         PH_GAP2: begin
            phase_in = PH_STATUS;
         end
         PH_T1END: begin
            if (in_char == CHAR_CLOSE) begin
               phase_in = PH_IDLE;
               if (!cur_lqi[0]) begin
                  push.count = 2'd1;
                  push.first = end_word(ERR_STATUS);
               end else begin
                  lqi_in = LINK_DEF;
                  push   = fin;
               end
            end else begin
               phase_in = PH_RSSI;
            end
         end
         PH_CLOSE: begin
            phase_in = PH_IDLE;
            if (in_char != CHAR_CLOSE) begin
               push.count = 2'd1;
               push.first = end_word(ERR_SYNTAX);
            end else if (cur_st) begin
               push.count = 2'd1;
               push.first = end_word(ERR_STATUS);
            end else begin
               push = fin;
            end
         end
         PH_LEN, PH_BYTE, PH_T1, PH_RSSI, PH_STATUS: begin
            if (!hx.ok) begin
               phase_in   = PH_IDLE;
               push.count = 2'd1;
               push.first = end_word(ERR_SYNTAX);
            end else if (!cur_dp) begin
               hn_in = hx.nibble;
               dp_in = 1'b1;
            end else begin
               dp_in = 1'b0;
               case (cur_phase)
                  PH_LEN: begin
                     if (v > MAX_V) begin
                        phase_in   = PH_IDLE;
                        push.count = 2'd1;
                        push.first = end_word(ERR_LENGTH);
                     end else begin
                        fl_in    = LW'(v);
                        bc_in    = '0;
                        phase_in = (v != 8'h00) ? PH_SEP : PH_GAP;
                     end
                  end
                  PH_BYTE: begin
                     crc_in   = crc_byte(cur_crc, v);
                     bc_in    = bc_next[LW-1:0];
                     phase_in = (bc_next >= {1'b0, cur_fl}) ? PH_GAP : PH_SEP;
                     if (!held) begin
                        push.count            = 2'd1;
                        push.first.data_byte  = v;
                        push.first.byte_valid = 1'b1;
                        push.first.error_code = ERR_OK;
                     end
                  end
                  PH_T1: begin
                     lqi_in   = v;
                     phase_in = PH_T1END;
                  end
                  PH_RSSI: begin
                     rssi_in  = v;
                     phase_in = PH_GAP2;
                  end
                  default: begin
                     st_in    = v[0];
                     phase_in = PH_CLOSE;
                  end
               endcase
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         fl_ff    <= '0;
         bc_ff    <= '0;
         crc_ff   <= '0;
         hn_ff    <= '0;
         dp_ff    <= 1'b0;
         lqi_ff   <= LINK_DEF;
         rssi_ff  <= LINK_DEF;
         st_ff    <= 1'b0;
      end else if (take) begin
         phase_ff <= phase_in;
         fl_ff    <= fl_in;
         bc_ff    <= bc_in;
         crc_ff   <= crc_in;
         hn_ff    <= hn_in;
         dp_ff    <= dp_in;
         lqi_ff   <= lqi_in;
         rssi_ff  <= rssi_in;
         st_ff    <= st_in;
      end
   end

endmodule

// ===== sv/hfp_rsp_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hex frame parser result queue
// Small queue that takes up to two result words per cycle and hands out one per cycle while pop is high.
// ----------------------------------------------------------------------------
module hfp_rsp_fifo (
   input  logic              clock,
   input  logic              reset,
   input  hfp_pkg::push_type push,
   input  logic              pop,
   output logic              room,
   output logic              not_empty,
   output hfp_pkg::rsp_type  head
);
   import hfp_pkg::*;

   rsp_type              mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [RSP_CNT_W-1:0] cnt_ff, cnt_in;
   logic [RSP_PTR_W-1:0] wr_next;

   assign wr_next   = wr_ff + RSP_PTR_W'(1);
   assign wr_in     = wr_ff + RSP_PTR_W'(push.count);
   assign rd_in     = rd_ff + RSP_PTR_W'(pop);
   assign cnt_in    = cnt_ff + RSP_CNT_W'(push.count) - RSP_CNT_W'(pop);
   assign room      = cnt_ff <= RSP_CNT_W'(RSP_DEPTH - 2);
   assign not_empty = cnt_ff != '0;
   assign head      = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== sv/hfp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hex frame parser port checker
// Checks result words seen on the top-level ports over time.
// ----------------------------------------------------------------------------
module hfp_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_data_byte,
   input logic       rsp_byte_valid,
   input logic       rsp_last,
   input logic [1:0] rsp_error_code
);

   // A stalled word stays on the ports unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data_byte)
         && $stable(rsp_byte_valid) && $stable(rsp_last) && $stable(rsp_error_code))
      else $error("stalled response word changed");

   // Only the closing word of a frame carries an error code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_error_code == 2'd0)
      else $error("error code on a word that is not last");

   // A word without a data byte is always a closing word with zero data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_last && rsp_data_byte == 8'h00)
      else $error("empty word that is not a closing word");

   // A failed frame never ends on a data byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code != 2'd0 |-> !rsp_byte_valid)
      else $error("error code on a data word");

   // Nothing is offered in the cycle after reset.
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("response word right after reset");

endmodule

bind hex_frame_parser_crc_lqi_top hfp_checker u_hfp_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_data_byte  (rsp_data_byte),
   .rsp_byte_valid (rsp_byte_valid),
   .rsp_last       (rsp_last),
   .rsp_error_code (rsp_error_code)
);
